FILE: sv/cwgr_pkg.sv
// ----------------------------------------------------------------------------
// cwgr_pkg
// Shared types and widths for the conducting wall ghost-cell reflector.
// ----------------------------------------------------------------------------
package cwgr_pkg;

	// Data word, signed fixed point.
	localparam int DATA_WIDTH = 32;

	// Unit normal scaling: components are unsigned Q1.30 magnitudes.
	localparam int UNIT_SHIFT = DATA_WIDTH - 2;
	localparam int UNIT_W     = DATA_WIDTH - 1;

	// Normal magnitude path.
	localparam int MAG_W      = DATA_WIDTH;
	localparam int NRM_W      = DATA_WIDTH - 1;
	localparam int LZ_W       = $clog2(NRM_W);
	localparam int SQR_W      = 2 * NRM_W;

	// Square root: one result bit per stage.
	localparam int ROOT_W     = NRM_W + 1;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int SREM_W     = ROOT_W + 2;
	localparam int SQRT_STEPS = ROOT_W;

	// Unit component divide: one quotient bit per stage.
	localparam int NUM_W      = NRM_W + UNIT_SHIFT + 1;
	localparam int DIV_STEPS  = UNIT_W;

	// Reflection arithmetic widths.
	localparam int P_W        = 2 * DATA_WIDTH;
	localparam int D_W        = DATA_WIDTH + 2;
	localparam int T_W        = D_W + DATA_WIDTH;
	localparam int TV_W       = D_W + 1;
	localparam int E_W        = TV_W + 1;

	typedef logic signed [DATA_WIDTH-1:0] word_t;

	localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	typedef enum logic [1:0] {
		OP_MIRROR     = 2'd0,
		OP_ANTIMIRROR = 2'd1,
		OP_COPY       = 2'd2,
		OP_NEGATE     = 2'd3
	} op_t;

	// Payload that rides alongside the normal computation.
	typedef struct packed {
		op_t   opcode;
		word_t cx;
		word_t cy;
		word_t cz;
	} side_t;

	// Unit normal as magnitudes with the raw signs.
	typedef struct packed {
		logic [UNIT_W-1:0] ux;
		logic [UNIT_W-1:0] uy;
		logic              sx;
		logic              sy;
		logic              bad;
	} unit_t;

endpackage

FILE: sv/cwgr_unit_norm.sv
// ----------------------------------------------------------------------------
// cwgr_unit_norm
// Pipelined normalization of a raw 2D face normal to a unit vector of Q1.30 magnitudes:
// magnitude scaling, squares, a bit-per-stage square root and two
// bit-per-stage dividers. A side payload travels with each beat.
// ----------------------------------------------------------------------------
module cwgr_unit_norm
	import cwgr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  word_t nx,
	input  word_t ny,
	input  side_t in_side,
	output logic  out_vld,
	output unit_t unit,
	output side_t out_side
);

	typedef struct packed {
		logic [NRM_W-1:0] ax;
		logic [NRM_W-1:0] ay;
		logic             sx;
		logic             sy;
		logic             bad;
		side_t            side;
	} carry_t;

	// Stage 1: absolute values and the zero-normal flag.
	logic [MAG_W-1:0] nx_u;
	logic [MAG_W-1:0] ny_u;
	logic [MAG_W-1:0] absx;
	logic [MAG_W-1:0] absy;

	logic             v_s1;
	logic [MAG_W-1:0] ax_s1;
	logic [MAG_W-1:0] ay_s1;
	logic             sx_s1;
	logic             sy_s1;
	logic             bad_s1;
	side_t            side_s1;

	assign nx_u = nx;
	assign ny_u = ny;
	assign absx = nx_u[MAG_W-1] ? (~nx_u + MAG_W'(1)) : nx_u;
	assign absy = ny_u[MAG_W-1] ? (~ny_u + MAG_W'(1)) : ny_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= absx;
			ay_s1   <= absy;
			sx_s1   <= nx_u[MAG_W-1];
			sy_s1   <= ny_u[MAG_W-1];
			bad_s1  <= (absx == '0) && (absy == '0);
			side_s1 <= in_side;
		end
	end

	// Stage 2: bring both magnitudes below the top bit, count leading zeros.
	logic             big;
	logic [NRM_W-1:0] px;
	logic [NRM_W-1:0] py;
	logic [NRM_W-1:0] por;
	logic [LZ_W-1:0]  lz;

	logic             v_s2;
	logic [NRM_W-1:0] px_s2;
	logic [NRM_W-1:0] py_s2;
	logic [LZ_W-1:0]  lz_s2;
	logic             sx_s2;
	logic             sy_s2;
	logic             bad_s2;
	side_t            side_s2;

	assign big = ax_s1[MAG_W-1] | ay_s1[MAG_W-1];
	assign px  = big ? ax_s1[MAG_W-1:1] : ax_s1[NRM_W-1:0];
	assign py  = big ? ay_s1[MAG_W-1:1] : ay_s1[NRM_W-1:0];
	assign por = px | py;

	always_comb begin
		lz = '0;
		for (int i = 0; i < NRM_W; i++) begin
			if (por[i]) begin
				lz = LZ_W'(NRM_W - 1 - i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2   <= px;
			py_s2   <= py;
			lz_s2   <= lz;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			bad_s2  <= bad_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: shift up until the larger magnitude reaches the top bit.
	logic   v_s3;
	carry_t car_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s3.ax   <= px_s2 << lz_s2;
			car_s3.ay   <= py_s2 << lz_s2;
			car_s3.sx   <= sx_s2;
			car_s3.sy   <= sy_s2;
			car_s3.bad  <= bad_s2;
			car_s3.side <= side_s2;
		end
	end

	// Stage 4: squares of both magnitudes.
	logic [SQR_W-1:0] sqx;
	logic [SQR_W-1:0] sqy;

	logic             v_s4;
	logic [SQR_W-1:0] sqx_s4;
	logic [SQR_W-1:0] sqy_s4;
	carry_t           car_s4;

	assign sqx = SQR_W'(car_s3.ax) * SQR_W'(car_s3.ax);
	assign sqy = SQR_W'(car_s3.ay) * SQR_W'(car_s3.ay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s4 <= sqx;
			sqy_s4 <= sqy;
			car_s4 <= car_s3;
		end
	end

	// Stage 5: sum of squares, the square root radicand.
	logic             v_s5;
	logic [RAD_W-1:0] rad_s5;
	carry_t           car_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5 <= RAD_W'(sqx_s4) + RAD_W'(sqy_s4);
			car_s5 <= car_s4;
		end
	end

	// Square root, restoring, one root bit per stage from the top pair down.
	logic              sv_s    [SQRT_STEPS];
	logic [SREM_W-1:0] srem_s  [SQRT_STEPS];
	logic [ROOT_W-1:0] sroot_s [SQRT_STEPS];
	logic [RAD_W-1:0]  srad_s  [SQRT_STEPS];
	carry_t            scar_s  [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic              vin;
		logic [SREM_W-1:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		carry_t            car_in;
		logic [SREM_W-1:0] rem_sh;
		logic [SREM_W-1:0] trial;
		logic              fit;

		if (k == 0) begin : g_first
			assign vin     = v_s5;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad_s5;
			assign car_in  = car_s5;
		end else begin : g_next
			assign vin     = sv_s[k-1];
			assign rem_in  = srem_s[k-1];
			assign root_in = sroot_s[k-1];
			assign rad_in  = srad_s[k-1];
			assign car_in  = scar_s[k-1];
		end

		assign rem_sh = {rem_in[SREM_W-3:0], rad_in[RAD_W-1-2*k -: 2]};
		assign trial  = {root_in, 2'b01};
		assign fit    = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[k] <= 1'b0;
			end else if (en) begin
				sv_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				srem_s[k]  <= fit ? (rem_sh - trial) : rem_sh;
				sroot_s[k] <= {root_in[ROOT_W-2:0], fit};
				srad_s[k]  <= rad_in;
				scar_s[k]  <= car_in;
			end
		end
	end

	// Divider setup: numerators carry the half-divisor rounding term.
	logic              v_sn;
	logic [NUM_W-1:0]  numx_sn;
	logic [NUM_W-1:0]  numy_sn;
	logic [ROOT_W-1:0] s_sn;
	carry_t            car_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (en) begin
			v_sn <= sv_s[SQRT_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_sn <= NUM_W'({scar_s[SQRT_STEPS-1].ax, {UNIT_SHIFT{1'b0}}})
				+ NUM_W'(sroot_s[SQRT_STEPS-1] >> 1);
			numy_sn <= NUM_W'({scar_s[SQRT_STEPS-1].ay, {UNIT_SHIFT{1'b0}}})
				+ NUM_W'(sroot_s[SQRT_STEPS-1] >> 1);
			s_sn    <= sroot_s[SQRT_STEPS-1];
			car_sn  <= scar_s[SQRT_STEPS-1];
		end
	end

	// Two restoring dividers side by side, one quotient bit per stage.
	logic              dv_s  [DIV_STEPS];
	logic [ROOT_W-1:0] drx_s [DIV_STEPS];
	logic [ROOT_W-1:0] dry_s [DIV_STEPS];
	logic [UNIT_W-1:0] dqx_s [DIV_STEPS];
	logic [UNIT_W-1:0] dqy_s [DIV_STEPS];
	logic [NUM_W-1:0]  dnx_s [DIV_STEPS];
	logic [NUM_W-1:0]  dny_s [DIV_STEPS];
	logic [ROOT_W-1:0] ds_s  [DIV_STEPS];
	carry_t            dcar_s[DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic              vin;
		logic [ROOT_W-1:0] rx_in;
		logic [ROOT_W-1:0] ry_in;
		logic [UNIT_W-1:0] qx_in;
		logic [UNIT_W-1:0] qy_in;
		logic [NUM_W-1:0]  nx_in;
		logic [NUM_W-1:0]  ny_in;
		logic [ROOT_W-1:0] s_in;
		carry_t            car_in;
		logic [ROOT_W:0]   rx;
		logic [ROOT_W:0]   ry;
		logic              fitx;
		logic              fity;

		if (j == 0) begin : g_first
			assign vin    = v_sn;
			assign rx_in  = ROOT_W'(numx_sn[NUM_W-1:DIV_STEPS]);
			assign ry_in  = ROOT_W'(numy_sn[NUM_W-1:DIV_STEPS]);
			assign qx_in  = '0;
			assign qy_in  = '0;
			assign nx_in  = numx_sn;
			assign ny_in  = numy_sn;
			assign s_in   = s_sn;
			assign car_in = car_sn;
		end else begin : g_next
			assign vin    = dv_s[j-1];
			assign rx_in  = drx_s[j-1];
			assign ry_in  = dry_s[j-1];
			assign qx_in  = dqx_s[j-1];
			assign qy_in  = dqy_s[j-1];
			assign nx_in  = dnx_s[j-1];
			assign ny_in  = dny_s[j-1];
			assign s_in   = ds_s[j-1];
			assign car_in = dcar_s[j-1];
		end

		assign rx   = {rx_in, nx_in[DIV_STEPS-1-j]};
		assign ry   = {ry_in, ny_in[DIV_STEPS-1-j]};
		assign fitx = (rx >= {1'b0, s_in});
		assign fity = (ry >= {1'b0, s_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j] <= 1'b0;
			end else if (en) begin
				dv_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				drx_s[j]  <= fitx ? ROOT_W'(rx - {1'b0, s_in}) : ROOT_W'(rx);
				dry_s[j]  <= fity ? ROOT_W'(ry - {1'b0, s_in}) : ROOT_W'(ry);
				dqx_s[j]  <= {qx_in[UNIT_W-2:0], fitx};
				dqy_s[j]  <= {qy_in[UNIT_W-2:0], fity};
				dnx_s[j]  <= nx_in;
				dny_s[j]  <= ny_in;
				ds_s[j]   <= s_in;
				dcar_s[j] <= car_in;
			end
		end
	end

	// A zero normal has no direction: its unit vector reads as zero.
	always_comb begin
		out_vld  = dv_s[DIV_STEPS-1];
		unit.ux  = dcar_s[DIV_STEPS-1].bad ? '0 : dqx_s[DIV_STEPS-1];
		unit.uy  = dcar_s[DIV_STEPS-1].bad ? '0 : dqy_s[DIV_STEPS-1];
		unit.sx  = dcar_s[DIV_STEPS-1].sx;
		unit.sy  = dcar_s[DIV_STEPS-1].sy;
		unit.bad = dcar_s[DIV_STEPS-1].bad;
		out_side = dcar_s[DIV_STEPS-1].side;
	end

endmodule

FILE: sv/conducting_wall_ghost_reflect.sv
// ----------------------------------------------------------------------------
// conducting_wall_ghost_reflect
// Throughput: one beat per cycle while the skid stage is empty, set by the fully
// pipelined square root and divider stages (one result bit per stage).
// A two-entry output register and skid stage keep the input open while a
// result waits. Reset is asynchronous and clears every valid bit.
// ----------------------------------------------------------------------------
module conducting_wall_ghost_reflect
	import cwgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  word_t       normal_x,
	input  word_t       normal_y,
	input  word_t       comp_x,
	input  word_t       comp_y,
	input  word_t       comp_z,
	output logic        out_valid,
	input  logic        out_ready,
	output word_t       ghost_x,
	output word_t       ghost_y,
	output word_t       ghost_z,
	output logic        bad_normal
);

	typedef struct packed {
		word_t gx;
		word_t gy;
		word_t gz;
		logic  bad;
	} res_t;

	// Half an LSB after the Q2.30 product shift, round half up.
	localparam logic signed [P_W:0] D_RND =
		{{(P_W+1-UNIT_SHIFT){1'b0}}, 1'b1, {(UNIT_SHIFT-1){1'b0}}};
	localparam logic signed [T_W:0] T_RND =
		{{(T_W+1-UNIT_SHIFT){1'b0}}, 1'b1, {(UNIT_SHIFT-1){1'b0}}};

	// Optional negation, then clamp to the signed word range.
	function automatic word_t sat_word(input logic signed [E_W-1:0] e, input logic neg);
		logic signed [E_W:0] f;
		begin
			f = neg ? -(E_W+1)'(e) : (E_W+1)'(e);
			if ((&f[E_W:DATA_WIDTH-1]) || !(|f[E_W:DATA_WIDTH-1])) begin
				sat_word = f[DATA_WIDTH-1:0];
			end else begin
				sat_word = f[E_W] ? WORD_MIN : WORD_MAX;
			end
		end
	endfunction

	logic  en;
	logic  skid_v_q;
	logic  out_v_q;
	res_t  skid_q;
	res_t  out_q;
	res_t  res;
	logic  push;

	// The whole pipeline moves unless the skid stage is holding a beat.
	assign en       = ~skid_v_q;
	assign in_ready = en;

	// Unit normal pipeline, with the opcode and components riding along.
	side_t in_side;
	logic  u_vld;
	unit_t u;
	side_t u_side;

	always_comb begin
		in_side.opcode = op_t'(opcode);
		in_side.cx     = comp_x;
		in_side.cy     = comp_y;
		in_side.cz     = comp_z;
	end

	cwgr_unit_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.nx       (normal_x),
		.ny       (normal_y),
		.in_side  (in_side),
		.out_vld  (u_vld),
		.unit     (u),
		.out_side (u_side)
	);

	// Stage 1: signed unit components and the products c times u.
	// Copy and negate use a zero vector, so the reflection term vanishes.
	logic              use_u;
	logic [UNIT_W-1:0] uxm;
	logic [UNIT_W-1:0] uym;
	word_t             uxs;
	word_t             uys;

	logic                  v_s1;
	logic signed [P_W-1:0] px_s1;
	logic signed [P_W-1:0] py_s1;
	word_t                 uxs_s1;
	word_t                 uys_s1;
	side_t                 side_s1;
	logic                  bad_s1;

	assign use_u = !(u_side.opcode == OP_COPY || u_side.opcode == OP_NEGATE);
	assign uxm   = use_u ? u.ux : '0;
	assign uym   = use_u ? u.uy : '0;
	assign uxs   = u.sx ? -$signed({1'b0, uxm}) : $signed({1'b0, uxm});
	assign uys   = u.sy ? -$signed({1'b0, uym}) : $signed({1'b0, uym});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= u_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= P_W'($signed(u_side.cx)) * P_W'(uxs);
			py_s1   <= P_W'($signed(u_side.cy)) * P_W'(uys);
			uxs_s1  <= uxs;
			uys_s1  <= uys;
			side_s1 <= u_side;
			bad_s1  <= u.bad;
		end
	end

	// Stage 2: dot product, rounded back to the data format.
	logic signed [P_W:0] dsum;

	logic                  v_s2;
	logic signed [D_W-1:0] d_s2;
	word_t                 uxs_s2;
	word_t                 uys_s2;
	side_t                 side_s2;
	logic                  bad_s2;

	assign dsum = (P_W+1)'(px_s1) + (P_W+1)'(py_s1) + D_RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2    <= D_W'(dsum >>> UNIT_SHIFT);
			uxs_s2  <= uxs_s1;
			uys_s2  <= uys_s1;
			side_s2 <= side_s1;
			bad_s2  <= bad_s1;
		end
	end

	// Stage 3: reflection products d times u.
	logic                  v_s3;
	logic signed [T_W-1:0] tx_s3;
	logic signed [T_W-1:0] ty_s3;
	side_t                 side_s3;
	logic                  bad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s3   <= T_W'(d_s2) * T_W'(uxs_s2);
			ty_s3   <= T_W'(d_s2) * T_W'(uys_s2);
			side_s3 <= side_s2;
			bad_s3  <= bad_s2;
		end
	end

	// Stage 4: double the product for the factor of two, then round.
	logic signed [T_W:0] tx2;
	logic signed [T_W:0] ty2;

	logic                   v_s4;
	logic signed [TV_W-1:0] tx_s4;
	logic signed [TV_W-1:0] ty_s4;
	side_t                  side_s4;
	logic                   bad_s4;

	assign tx2 = $signed({tx_s3, 1'b0}) + T_RND;
	assign ty2 = $signed({ty_s3, 1'b0}) + T_RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s4   <= TV_W'(tx2 >>> UNIT_SHIFT);
			ty_s4   <= TV_W'(ty2 >>> UNIT_SHIFT);
			side_s4 <= side_s3;
			bad_s4  <= bad_s3;
		end
	end

	// Stage 5: mirrored components; antimirror and negate flip the sign later.
	logic                  v_s5;
	logic signed [E_W-1:0] ex_s5;
	logic signed [E_W-1:0] ey_s5;
	logic signed [E_W-1:0] ez_s5;
	logic                  neg_s5;
	logic                  bad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s5  <= E_W'($signed(side_s4.cx)) - E_W'(tx_s4);
			ey_s5  <= E_W'($signed(side_s4.cy)) - E_W'(ty_s4);
			ez_s5  <= E_W'($signed(side_s4.cz));
			neg_s5 <= (side_s4.opcode == OP_ANTIMIRROR) || (side_s4.opcode == OP_NEGATE);
			bad_s5 <= bad_s4;
		end
	end

	// Final saturation feeds the output register or the skid stage.
	always_comb begin
		res.gx  = sat_word(ex_s5, neg_s5);
		res.gy  = sat_word(ey_s5, neg_s5);
		res.gz  = sat_word(ez_s5, neg_s5);
		res.bad = bad_s5;
	end

	assign push = en & v_s5;

	// Output register with a skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q  <= skid_v_q | push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid  = out_v_q;
	assign ghost_x    = out_q.gx;
	assign ghost_y    = out_q.gy;
	assign ghost_z    = out_q.gz;
	assign bad_normal = out_q.bad;

	// The skid stage only holds a beat behind an occupied output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage full while output register is empty");

	// The skid stage fills only when the output beat was stalled.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !out_ready))
		else $error("skid stage filled without an output stall");

	// A held skid beat is neither lost nor overwritten while the output stalls.
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_ready |=> skid_v_q && $stable(skid_q))
		else $error("skid beat changed during an output stall");

endmodule

FILE: tb/sv/ghost_reflect_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghost_reflect_checker
// Watches both channels of the ghost-cell reflector. Each accepted face
// beat is turned into its expected ghost values, which wait in order.
// Each accepted result beat is compared field by field with the oldest
// expected ghost. The failure count and the number of ghosts still pending
// go to the testbench top.
// ----------------------------------------------------------------------------
module ghost_reflect_checker
	import cwgr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] opcode,
	input  word_t      normal_x,
	input  word_t      normal_y,
	input  word_t      comp_x,
	input  word_t      comp_y,
	input  word_t      comp_z,
	input  logic       out_valid,
	input  logic       out_ready,
	input  word_t      ghost_x,
	input  word_t      ghost_y,
	input  word_t      ghost_z,
	input  logic       bad_normal,
	output int         fail_count,
	output int         pending
);

	// Exact intermediate arithmetic, wide enough for every product.
	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		word_t gx;
		word_t gy;
		word_t gz;
		logic  bad;
	} ghost_t;

	localparam wide_t  HALF_LSB  = wide_t'(1) <<< (UNIT_SHIFT - 1);

	ghost_t ghost_q[$];

	// Integer square root, floor, one result bit per radicand bit pair.
	function automatic logic [63:0] root_floor(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] bitv;
		rem  = x;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem  = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Round half up and drop the Q2.30 fraction of the unit normal.
	function automatic wide_t round_unit(input wide_t v);
		wide_t t;
		t = v + HALF_LSB;
		return t >>> UNIT_SHIFT;
	endfunction

	// Saturate to the signed data word.
	function automatic word_t clamp_word(input wide_t v);
		if (v > wide_t'(WORD_MAX))
			return WORD_MAX;
		if (v < wide_t'(WORD_MIN))
			return WORD_MIN;
		return word_t'(v);
	endfunction

	// Expected ghost group for one face beat.
	function automatic ghost_t reflect_ghost(input op_t op, input word_t nx, input word_t ny,
			input word_t cx, input word_t cy, input word_t cz);
		ghost_t      g;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] s;
		logic [63:0] ux;
		logic [63:0] uy;
		logic        sx;
		logic        sy;
		logic        bad;
		wide_t       wx;
		wide_t       wy;
		wide_t       wz;
		wide_t       kx;
		wide_t       ky;
		wide_t       dot;
		wide_t       tx;
		wide_t       ty;
		sx = nx[DATA_WIDTH-1];
		sy = ny[DATA_WIDTH-1];
		ax = sx ? (64'd0 - {{32{nx[31]}}, nx}) : {32'd0, nx};
		ay = sy ? (64'd0 - {{32{ny[31]}}, ny}) : {32'd0, ny};
		bad = (ax | ay) == 0;
		ux = '0;
		uy = '0;
		// Scale the magnitudes together until the larger is in [2^30, 2^31), then normalize.
		if (!bad) begin
			while ((ax | ay) >= 64'h8000_0000) begin
				ax = ax >> 1;
				ay = ay >> 1;
			end
			while ((ax | ay) < 64'h4000_0000) begin
				ax = ax << 1;
				ay = ay << 1;
			end
			s  = root_floor(ax * ax + ay * ay);
			ux = ((ax << UNIT_SHIFT) + (s >> 1)) / s;
			uy = ((ay << UNIT_SHIFT) + (s >> 1)) / s;
		end
		wx = cx;
		wy = cy;
		wz = cz;
		kx = ux;
		ky = uy;
		if (sx)
			kx = -kx;
		if (sy)
			ky = -ky;
		// Normal projection and the doubled reflection term.
		dot = round_unit(wx * kx + wy * ky);
		tx  = round_unit(dot * (kx <<< 1));
		ty  = round_unit(dot * (ky <<< 1));
		case (op)
			OP_MIRROR: begin
				g.gx = clamp_word(wx - tx);
				g.gy = clamp_word(wy - ty);
				g.gz = clamp_word(wz);
			end
			OP_ANTIMIRROR: begin
				g.gx = clamp_word(tx - wx);
				g.gy = clamp_word(ty - wy);
				g.gz = clamp_word(-wz);
			end
			OP_COPY: begin
				g.gx = clamp_word(wx);
				g.gy = clamp_word(wy);
				g.gz = clamp_word(wz);
			end
			default: begin
				g.gx = clamp_word(-wx);
				g.gy = clamp_word(-wy);
				g.gz = clamp_word(-wz);
			end
		endcase
		g.bad = bad;
		return g;
	endfunction

	// One line per mismatch, and every mismatch is counted.
	task automatic note_fail(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		fail_count = fail_count + 1;
	endtask

	// Record each face beat, check each result beat against the oldest ghost.
	always @(posedge clk or negedge arst_n) begin
		ghost_t want;
		if (!arst_n) begin
			ghost_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				ghost_q.push_back(reflect_ghost(op_t'(opcode), normal_x, normal_y,
					comp_x, comp_y, comp_z));
			if (out_valid && out_ready) begin
				if (ghost_q.size() == 0) begin
					note_fail("result beat with no face pending");
				end else begin
					want = ghost_q.pop_front();
					if (ghost_x !== want.gx)
						note_fail($sformatf("ghost_x got %h want %h", ghost_x, want.gx));
					if (ghost_y !== want.gy)
						note_fail($sformatf("ghost_y got %h want %h", ghost_y, want.gy));
					if (ghost_z !== want.gz)
						note_fail($sformatf("ghost_z got %h want %h", ghost_z, want.gz));
					if (bad_normal !== want.bad)
						note_fail($sformatf("bad_normal got %b want %b",
							bad_normal, want.bad));
				end
			end
			pending <= ghost_q.size();
		end
	end

endmodule

FILE: tb/sv/conducting_wall_ghost_reflect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conducting_wall_ghost_reflect_tb
// Drives face beats into the ghost-cell reflector: a directed set over the
// wall orientations, extreme values, zero normals and every opcode, then
// random faces sent in bursts while the result side stalls on its own
// pattern. A checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module conducting_wall_ghost_reflect_tb;
	import cwgr_pkg::*;

	localparam int    RANDOM_FACES = 1000;
	localparam int    PAUSE_AT     = 600;
	localparam int    HOLD_AT      = 300;
	localparam int    HOLD_CYCLES  = 400;
	localparam int    DRAIN_CYCLES = 120;
	localparam int    IDLE_LIMIT   = 4000;
	localparam word_t Q_ONE        = 32'sh0001_0000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] opcode;
	word_t      normal_x;
	word_t      normal_y;
	word_t      comp_x;
	word_t      comp_y;
	word_t      comp_z;
	logic       out_valid;
	logic       out_ready;
	word_t      ghost_x;
	word_t      ghost_y;
	word_t      ghost_z;
	logic       bad_normal;
	int         fail_count;
	int         pending;
	int         in_beats;
	int         idle_cycles;

	conducting_wall_ghost_reflect i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.comp_x     (comp_x),
		.comp_y     (comp_y),
		.comp_z     (comp_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ghost_x    (ghost_x),
		.ghost_y    (ghost_y),
		.ghost_z    (ghost_z),
		.bad_normal (bad_normal)
	);

	ghost_reflect_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.comp_x     (comp_x),
		.comp_y     (comp_y),
		.comp_z     (comp_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ghost_x    (ghost_x),
		.ghost_y    (ghost_y),
		.ghost_z    (ghost_z),
		.bad_normal (bad_normal),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 8 ns clock.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Count accepted face beats; the watchdog ends a run that stops moving.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_beats    <= 0;
			idle_cycles <= 0;
		end else begin
			if (in_valid && in_ready)
				in_beats <= in_beats + 1;
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
					$display("conducting_wall_ghost_reflect regression: fail");
					$finish;
				end
			end
		end
	end

	// Random word biased toward the extremes, zero and small magnitudes.
	function automatic word_t rand_word();
		case ($urandom_range(9, 0))
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2:       return '0;
			3, 4, 5: return word_t'($urandom_range(32'h000F_FFFF, 0)) - 32'sh0008_0000;
			default: return word_t'($urandom);
		endcase
	endfunction

	// Offer one face beat and hold it until the block takes it.
	task automatic offer_face(input op_t op, input word_t nx, input word_t ny,
			input word_t cx, input word_t cy, input word_t cz);
		in_valid <= 1'b1;
		opcode   <= op;
		normal_x <= nx;
		normal_y <= ny;
		comp_x   <= cx;
		comp_y   <= cy;
		comp_z   <= cz;
		do @(posedge clk); while (!in_ready);
	endtask

	// Result side: stall modes that change now and then, plus one long hold.
	initial begin : result_side
		int  mode;
		int  mode_left;
		int  hold_left;
		int  cyc;
		bit  hold_done;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		cyc       = 0;
		hold_done = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc = cyc + 1;
			if (mode_left == 0) begin
				mode      = $urandom_range(4, 0);
				mode_left = $urandom_range(200, 20);
			end
			mode_left = mode_left - 1;
			if (!hold_done && in_beats >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= $urandom_range(1, 0);
					2:       out_ready <= ($urandom_range(7, 0) != 0);
					3:       out_ready <= ($urandom_range(3, 0) == 0);
					default: out_ready <= (cyc % 5) != 0;
				endcase
			end
		end
	end

	// Face side: reset, directed faces, random bursts, drain and verdict.
	initial begin : face_side
		int    sent;
		int    burst;
		int    gap;
		op_t   op;
		word_t nx;
		word_t ny;
		in_valid <= 1'b0;
		opcode   <= OP_MIRROR;
		normal_x <= '0;
		normal_y <= '0;
		comp_x   <= '0;
		comp_y   <= '0;
		comp_z   <= '0;
		arst_n   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Axis-aligned, diagonal and skewed walls for the vector opcodes.
		offer_face(OP_MIRROR, Q_ONE, '0, 3 * Q_ONE, 2 * Q_ONE, Q_ONE);
		offer_face(OP_MIRROR, '0, Q_ONE, 3 * Q_ONE, -2 * Q_ONE, Q_ONE);
		offer_face(OP_MIRROR, Q_ONE, Q_ONE, Q_ONE, 5 * Q_ONE, -Q_ONE);
		offer_face(OP_ANTIMIRROR, -Q_ONE, '0, 7 * Q_ONE, Q_ONE, 4 * Q_ONE);
		offer_face(OP_ANTIMIRROR, Q_ONE, -2 * Q_ONE, -Q_ONE, 3 * Q_ONE, Q_ONE);
		offer_face(OP_MIRROR, 32'sd3, 32'sd4, 32'sh1234_5678, -32'sh0765_4321, 32'sd17);

		// Scalars: copy and negate, including negation of the most negative word.
		offer_face(OP_COPY, Q_ONE, '0, WORD_MAX, WORD_MIN, '0);
		offer_face(OP_NEGATE, '0, Q_ONE, WORD_MIN, WORD_MAX, -32'sd1);
		offer_face(OP_COPY, -Q_ONE, Q_ONE, 5 * Q_ONE, 32'sh0bad_f00d, -32'sh0000_0001);
		offer_face(OP_NEGATE, Q_ONE, Q_ONE, 2 * Q_ONE, WORD_MIN, WORD_MIN);

		// Zero-length normal with every opcode.
		for (int k = 0; k < 4; k++)
			offer_face(op_t'(k), '0, '0, 3 * Q_ONE, -Q_ONE, WORD_MIN);

		// Extreme normals and saturating components.
		offer_face(OP_MIRROR, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
		offer_face(OP_ANTIMIRROR, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN);
		offer_face(OP_MIRROR, WORD_MIN, '0, WORD_MIN, WORD_MIN, WORD_MIN);
		offer_face(OP_ANTIMIRROR, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
		offer_face(OP_MIRROR, 32'sd1, '0, WORD_MAX, -Q_ONE, Q_ONE);
		offer_face(OP_ANTIMIRROR, '0, -32'sd1, WORD_MAX, WORD_MAX, WORD_MIN);
		offer_face(OP_MIRROR, WORD_MAX, 32'sd1, WORD_MIN, WORD_MAX, '0);
		offer_face(OP_ANTIMIRROR, -32'sd1, 32'sd1, WORD_MAX, WORD_MAX, '0);
		in_valid <= 1'b0;
		repeat (3) @(posedge clk);

		// Random faces in bursts of random length with random gaps.
		sent = 0;
		while (sent < RANDOM_FACES) begin
			burst = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 80)
				: $urandom_range(24, 1);
			for (int i = 0; i < burst && sent < RANDOM_FACES; i++) begin
				op = op_t'($urandom_range(3, 0));
				case ($urandom_range(19, 0))
					0: begin
						nx = '0;
						ny = '0;
					end
					1: begin
						nx = rand_word();
						ny = '0;
					end
					2: begin
						nx = '0;
						ny = rand_word();
					end
					default: begin
						nx = rand_word();
						ny = rand_word();
					end
				endcase
				offer_face(op, nx, ny, rand_word(), rand_word(), rand_word());
				sent = sent + 1;
				// Once, stop sending until every pending ghost has come out.
				if (sent == PAUSE_AT) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
			gap = $urandom_range(12, 0);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		// Drain, then watch a while longer for stray result beats.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("conducting_wall_ghost_reflect regression: pass");
		end else begin
			$display("conducting_wall_ghost_reflect regression: fail");
		end
		$finish;
	end

endmodule
